### rtl/dnsp_pkg.sv
// ----------------------------------------------------------------------------
// DNS answer parser package
// Shared types and constants for the DNS response A-record parser.
// ----------------------------------------------------------------------------
package dnsp_pkg;

  localparam int unsigned HeaderLen = 12;
  localparam int unsigned FixedLen  = 10;

  localparam logic [7:0]  PtrMask   = 8'hC0;
  localparam logic [15:0] QrBit     = 16'h8000;
  localparam logic [15:0] RcodeMask = 16'h000F;
  localparam logic [15:0] TypeA     = 16'h0001;
  localparam logic [15:0] AddrLen   = 16'd4;
  localparam logic [15:0] QFixedLen = 16'd4;

  // Result status codes.
  localparam logic [2:0] StFound       = 3'd0;
  localparam logic [2:0] StNotResponse = 3'd1;
  localparam logic [2:0] StRcodeError  = 3'd2;
  localparam logic [2:0] StNoARecord   = 3'd3;
  localparam logic [2:0] StTruncated   = 3'd4;

  typedef enum logic [11:0] {
    PH_HEADER  = 12'b0000_0000_0001,
    PH_Q_LEN   = 12'b0000_0000_0010,
    PH_Q_LABEL = 12'b0000_0000_0100,
    PH_Q_PTR   = 12'b0000_0000_1000,
    PH_Q_FIXED = 12'b0000_0001_0000,
    PH_A_LEN   = 12'b0000_0010_0000,
    PH_A_LABEL = 12'b0000_0100_0000,
    PH_A_PTR   = 12'b0000_1000_0000,
    PH_A_FIXED = 12'b0001_0000_0000,
    PH_A_SKIP  = 12'b0010_0000_0000,
    PH_A_ADDR  = 12'b0100_0000_0000,
    PH_DONE    = 12'b1000_0000_0000
  } phase_t;

  typedef struct packed {
    phase_t      phase;
    logic [3:0]  byte_count;
    logic [15:0] header_flags;
    logic [15:0] questions_left;
    logic [15:0] answers_left;
    logic [15:0] record_kind;
    logic [15:0] data_left;
    logic [31:0] address_acc;
  } parse_state_t;

  typedef struct packed {
    logic        vld;
    logic [2:0]  status;
    logic [31:0] address;
  } parse_result_t;

  localparam parse_state_t StateReset = '{
    phase:          PH_HEADER,
    byte_count:     4'd0,
    header_flags:   16'd0,
    questions_left: 16'd0,
    answers_left:   16'd0,
    record_kind:    16'd0,
    data_left:      16'd0,
    address_acc:    32'd0
  };

endpackage

### rtl/dns_answer_address_parser_top.sv
// ----------------------------------------------------------------------------
// DNS answer address parser
// Reads a DNS response byte stream and reports the first IPv4 A record.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_vld / in_stall) carries one message byte per
//   transfer, with in_end_of_message high on the last byte of a message.
//   The result channel (out_vld / out_stall) carries one transfer per
//   message: out_status and out_address (zero unless the status is found).
//   A decision may come before the end marker; bytes after it are dropped
//   until the end marker, which returns the parser to the header phase.
//   A byte transfer is held in the byte register; its result goes through
//   the result register to out_vld. Throughput is one byte per cycle while
//   no result waits under out_stall: the byte register feeds the parser
//   state update, a single pass of narrow compare and decrement logic.
//   When the receiver holds out_stall with a result waiting, the byte
//   register stops draining and in_stall rises; no byte or result is lost.
//   Synchronous active-low reset empties both registers and puts the
//   parser in the header phase.
// ----------------------------------------------------------------------------
module dns_answer_address_parser_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_vld,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_end_of_message,
  output logic        out_vld,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic [31:0] out_address
);

  // Input byte register.
  logic       byte_vld_r;
  logic [7:0] byte_data_r;
  logic       byte_eom_r;

  // Parser state.
  dnsp_pkg::parse_state_t  state_r;
  dnsp_pkg::parse_state_t  state_nxt;
  dnsp_pkg::parse_result_t step_res;

  // Result register.
  logic        out_vld_r;
  logic [2:0]  out_status_r;
  logic [31:0] out_address_r;

  logic advance;
  logic in_xfer;

  // The held byte moves on whenever the result register can take a result.
  assign advance  = byte_vld_r && (!out_vld_r || !out_stall);
  assign in_stall = byte_vld_r && !advance;
  assign in_xfer  = in_vld && !in_stall;

  dnsp_step u_step (
    .cur            (state_r),
    .data_byte      (byte_data_r),
    .end_of_message (byte_eom_r),
    .nxt            (state_nxt),
    .res            (step_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_vld_r <= 1'b0;
    end else if (in_xfer) begin
      byte_vld_r <= 1'b1;
    end else if (advance) begin
      byte_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      byte_data_r <= in_data_byte;
      byte_eom_r  <= in_end_of_message;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= dnsp_pkg::StateReset;
    end else if (advance) begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance && step_res.vld) begin
      out_vld_r <= 1'b1;
    end else if (!out_stall) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && step_res.vld) begin
      out_status_r  <= step_res.status;
      out_address_r <= step_res.address;
    end
  end

  assign out_vld     = out_vld_r;
  assign out_status  = out_status_r;
  assign out_address = out_address_r;

endmodule

### rtl/dnsp_step.sv
// ----------------------------------------------------------------------------
// DNS answer parser step logic
// Combinational next-state and result logic for one message byte.
// ----------------------------------------------------------------------------
module dnsp_step (
  input  dnsp_pkg::parse_state_t  cur,
  input  logic [7:0]              data_byte,
  input  logic                    end_of_message,
  output dnsp_pkg::parse_state_t  nxt,
  output dnsp_pkg::parse_result_t res
);

  always_comb begin
    dnsp_pkg::parse_state_t s;
    logic                   dec;
    logic [2:0]             st;
    logic [3:0]             cnt;
    logic [15:0]            dl;
    logic [15:0]            cnt_q;
    logic [15:0]            cnt_a;

    s     = cur;
    dec   = 1'b0;
    st    = dnsp_pkg::StFound;
    cnt   = cur.byte_count + 4'd1;
    dl    = cur.data_left - 16'd1;
    cnt_q = cur.questions_left - 16'd1;
    cnt_a = cur.answers_left - 16'd1;

    case (cur.phase)
      dnsp_pkg::PH_HEADER: begin
        case (cur.byte_count)
          4'd2: s.header_flags   = {data_byte, 8'h00};
          4'd3: s.header_flags   = {cur.header_flags[15:8], data_byte};
          4'd4: s.questions_left = {data_byte, 8'h00};
          4'd5: s.questions_left = {cur.questions_left[15:8], data_byte};
          4'd6: s.answers_left   = {data_byte, 8'h00};
          4'd7: s.answers_left   = {cur.answers_left[15:8], data_byte};
          default: ;
        endcase
        s.byte_count = cnt;
        if (cnt == 4'(dnsp_pkg::HeaderLen)) begin
          if ((s.header_flags & dnsp_pkg::QrBit) == 16'd0) begin
            dec = 1'b1;
            st  = dnsp_pkg::StNotResponse;
          end else if ((s.header_flags & dnsp_pkg::RcodeMask) != 16'd0) begin
            dec = 1'b1;
            st  = dnsp_pkg::StRcodeError;
          end else if (s.questions_left != 16'd0) begin
            s.phase = dnsp_pkg::PH_Q_LEN;
          end else if (s.answers_left != 16'd0) begin
            s.phase = dnsp_pkg::PH_A_LEN;
          end else begin
            dec = 1'b1;
            st  = dnsp_pkg::StNoARecord;
          end
        end
      end
      dnsp_pkg::PH_Q_LEN, dnsp_pkg::PH_A_LEN: begin
        if (data_byte == 8'd0) begin
          if (cur.phase == dnsp_pkg::PH_A_LEN) begin
            s.phase       = dnsp_pkg::PH_A_FIXED;
            s.byte_count  = 4'd0;
            s.record_kind = 16'd0;
            s.data_left   = 16'd0;
          end else begin
            s.phase     = dnsp_pkg::PH_Q_FIXED;
            s.data_left = dnsp_pkg::QFixedLen;
          end
        end else if ((data_byte & dnsp_pkg::PtrMask) != 8'd0) begin
          s.phase = (cur.phase == dnsp_pkg::PH_A_LEN) ? dnsp_pkg::PH_A_PTR
                                                      : dnsp_pkg::PH_Q_PTR;
        end else begin
          s.data_left = {8'h00, data_byte};
          s.phase = (cur.phase == dnsp_pkg::PH_A_LEN) ? dnsp_pkg::PH_A_LABEL
                                                      : dnsp_pkg::PH_Q_LABEL;
        end
      end
      dnsp_pkg::PH_Q_LABEL: begin
        s.data_left = dl;
        if (dl == 16'd0) s.phase = dnsp_pkg::PH_Q_LEN;
      end
      dnsp_pkg::PH_A_LABEL: begin
        s.data_left = dl;
        if (dl == 16'd0) s.phase = dnsp_pkg::PH_A_LEN;
      end
      dnsp_pkg::PH_Q_PTR: begin
        s.phase     = dnsp_pkg::PH_Q_FIXED;
        s.data_left = dnsp_pkg::QFixedLen;
      end
      dnsp_pkg::PH_A_PTR: begin
        s.phase       = dnsp_pkg::PH_A_FIXED;
        s.byte_count  = 4'd0;
        s.record_kind = 16'd0;
        s.data_left   = 16'd0;
      end
      dnsp_pkg::PH_Q_FIXED: begin
        s.data_left = dl;
        if (dl == 16'd0) begin
          s.questions_left = cnt_q;
          if (cnt_q != 16'd0) begin
            s.phase = dnsp_pkg::PH_Q_LEN;
          end else if (cur.answers_left != 16'd0) begin
            s.phase = dnsp_pkg::PH_A_LEN;
          end else begin
            dec = 1'b1;
            st  = dnsp_pkg::StNoARecord;
          end
        end
      end
      dnsp_pkg::PH_A_FIXED: begin
        if (cur.byte_count < 4'd2) begin
          s.record_kind = {cur.record_kind[7:0], data_byte};
        end else if (cur.byte_count >= 4'd8) begin
          s.data_left = {cur.data_left[7:0], data_byte};
        end
        s.byte_count = cnt;
        if (cnt == 4'(dnsp_pkg::FixedLen)) begin
          if (s.record_kind == dnsp_pkg::TypeA && s.data_left == dnsp_pkg::AddrLen) begin
            s.address_acc = 32'd0;
            s.phase       = dnsp_pkg::PH_A_ADDR;
          end else if (s.data_left != 16'd0) begin
            s.phase = dnsp_pkg::PH_A_SKIP;
          end else begin
            // Empty RDATA: the record ends here.
            s.answers_left = cnt_a;
            if (cnt_a != 16'd0) begin
              s.phase = dnsp_pkg::PH_A_LEN;
            end else begin
              dec = 1'b1;
              st  = dnsp_pkg::StNoARecord;
            end
          end
        end
      end
      dnsp_pkg::PH_A_SKIP: begin
        s.data_left = dl;
        if (dl == 16'd0) begin
          s.answers_left = cnt_a;
          if (cnt_a != 16'd0) begin
            s.phase = dnsp_pkg::PH_A_LEN;
          end else begin
            dec = 1'b1;
            st  = dnsp_pkg::StNoARecord;
          end
        end
      end
      dnsp_pkg::PH_A_ADDR: begin
        s.address_acc = {cur.address_acc[23:0], data_byte};
        s.data_left   = dl;
        if (dl == 16'd0) begin
          dec = 1'b1;
          st  = dnsp_pkg::StFound;
        end
      end
      default: ;
    endcase

    if (dec) s.phase = dnsp_pkg::PH_DONE;

    res.vld     = 1'b0;
    res.status  = st;
    res.address = 32'd0;
    if (dec) begin
      res.vld     = 1'b1;
      res.address = (st == dnsp_pkg::StFound) ? s.address_acc : 32'd0;
    end else if (end_of_message && cur.phase != dnsp_pkg::PH_DONE) begin
      res.vld    = 1'b1;
      res.status = dnsp_pkg::StTruncated;
    end

    nxt = end_of_message ? dnsp_pkg::StateReset : s;
  end

endmodule

### verif/dns_answer_address_parser_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DNS answer address parser testbench
// Streams DNS response messages into the parser one byte per transfer and
// checks every result transfer against a cycle-free software copy of the
// parser. The run covers hand-built messages for the header rejects, name
// forms, record skipping and early ends, then a long series of randomized
// messages with random pacing on both channels.
// ----------------------------------------------------------------------------
module dns_answer_address_parser_top_tb;

  // A decision that has not been reached yet.
  localparam int NoDecision = -1;
  localparam int RandomBytes = 1650;
  localparam int HoldCycles = 400;
  localparam int HoldAfterBytes = 900;

  typedef struct {
    logic [7:0] data;
    logic       eom;
  } stream_byte_t;

  typedef struct {
    logic [2:0]  status;
    logic [31:0] address;
  } lookup_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_vld = 1'b0;
  logic        in_stall;
  logic [7:0]  in_data_byte = 8'h00;
  logic        in_end_of_message = 1'b0;
  logic        out_vld;
  logic        out_stall = 1'b0;
  logic [2:0]  out_status;
  logic [31:0] out_address;

  dns_answer_address_parser_top u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_vld            (in_vld),
    .in_stall          (in_stall),
    .in_data_byte      (in_data_byte),
    .in_end_of_message (in_end_of_message),
    .out_vld           (out_vld),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_address       (out_address)
  );

  always #5 clk = ~clk;

  // Bytes waiting to be offered, and results the parser still owes us.
  stream_byte_t   byte_stream[$];
  lookup_result_t awaited_results[$];
  // Scratch buffer for the message being assembled.
  logic [7:0]     msg_bytes[$];

  int mismatches = 0;
  int bytes_accepted = 0;
  int messages_ended = 0;
  int results_checked = 0;
  int status_seen[0:7];

  // --------------------------------------------------------------------------
  // Parser state mirror. It follows the byte stream at transfer granularity,
  // so it knows nothing about the two-stage pipeline inside the block.
  // --------------------------------------------------------------------------
  dnsp_pkg::phase_t ph;
  logic [15:0] field_pos;
  logic [15:0] flags;
  logic [15:0] qleft;
  logic [15:0] aleft;
  logic [15:0] rkind;
  logic [15:0] dleft;
  logic [31:0] acc;
  logic        decided;

  function automatic void clear_parser();
    ph        = dnsp_pkg::PH_HEADER;
    field_pos = '0;
    flags     = '0;
    qleft     = '0;
    aleft     = '0;
    rkind     = '0;
    dleft     = '0;
    acc       = '0;
    decided   = 1'b0;
  endfunction

  // When the answer count runs out the message is settled as "no A record".
  function automatic int start_answers();
    if (aleft == 16'd0) return int'(dnsp_pkg::StNoARecord);
    ph = dnsp_pkg::PH_A_LEN;
    return NoDecision;
  endfunction

  function automatic int start_questions();
    if (qleft == 16'd0) return start_answers();
    ph = dnsp_pkg::PH_Q_LEN;
    return NoDecision;
  endfunction

  function automatic int next_answer();
    aleft = aleft - 16'd1;
    return start_answers();
  endfunction

  function automatic void end_of_name(logic in_answer);
    if (in_answer) begin
      ph        = dnsp_pkg::PH_A_FIXED;
      field_pos = '0;
      rkind     = '0;
      dleft     = '0;
    end else begin
      ph    = dnsp_pkg::PH_Q_FIXED;
      dleft = dnsp_pkg::QFixedLen;
    end
  endfunction

  // A zero byte ends the name; any of the top two bits set means a
  // two-byte pointer, including the reserved forms; otherwise a label.
  function automatic void name_length(logic [7:0] b, logic in_answer);
    if (b == 8'h00) begin
      end_of_name(in_answer);
    end else if ((b & dnsp_pkg::PtrMask) != 8'h00) begin
      ph = in_answer ? dnsp_pkg::PH_A_PTR : dnsp_pkg::PH_Q_PTR;
    end else begin
      dleft = {8'h00, b};
      ph    = in_answer ? dnsp_pkg::PH_A_LABEL : dnsp_pkg::PH_Q_LABEL;
    end
  endfunction

  function automatic void label_body(logic in_answer);
    dleft = dleft - 16'd1;
    if (dleft == 16'd0) ph = in_answer ? dnsp_pkg::PH_A_LEN : dnsp_pkg::PH_Q_LEN;
  endfunction

  function automatic int consume_byte(logic [7:0] b);
    case (ph)
      dnsp_pkg::PH_HEADER: begin
        case (field_pos)
          16'd2: flags = {b, 8'h00};
          16'd3: flags = {flags[15:8], b};
          16'd4: qleft = {b, 8'h00};
          16'd5: qleft = {qleft[15:8], b};
          16'd6: aleft = {b, 8'h00};
          16'd7: aleft = {aleft[15:8], b};
          default: ;
        endcase
        field_pos = field_pos + 16'd1;
        if (field_pos < dnsp_pkg::HeaderLen) return NoDecision;
        if ((flags & dnsp_pkg::QrBit) == 16'd0) return int'(dnsp_pkg::StNotResponse);
        if ((flags & dnsp_pkg::RcodeMask) != 16'd0) return int'(dnsp_pkg::StRcodeError);
        return start_questions();
      end
      dnsp_pkg::PH_Q_LEN: begin
        name_length(b, 1'b0);
        return NoDecision;
      end
      dnsp_pkg::PH_Q_LABEL: begin
        label_body(1'b0);
        return NoDecision;
      end
      dnsp_pkg::PH_Q_PTR: begin
        end_of_name(1'b0);
        return NoDecision;
      end
      dnsp_pkg::PH_Q_FIXED: begin
        dleft = dleft - 16'd1;
        if (dleft != 16'd0) return NoDecision;
        qleft = qleft - 16'd1;
        return start_questions();
      end
      dnsp_pkg::PH_A_LEN: begin
        name_length(b, 1'b1);
        return NoDecision;
      end
      dnsp_pkg::PH_A_LABEL: begin
        label_body(1'b1);
        return NoDecision;
      end
      dnsp_pkg::PH_A_PTR: begin
        end_of_name(1'b1);
        return NoDecision;
      end
      dnsp_pkg::PH_A_FIXED: begin
        // TYPE sits in the first two bytes, RDLENGTH in the last two.
        if (field_pos < 16'd2) rkind = {rkind[7:0], b};
        else if (field_pos >= 16'd8) dleft = {dleft[7:0], b};
        field_pos = field_pos + 16'd1;
        if (field_pos < dnsp_pkg::FixedLen) return NoDecision;
        if (rkind == dnsp_pkg::TypeA && dleft == dnsp_pkg::AddrLen) begin
          acc = '0;
          ph  = dnsp_pkg::PH_A_ADDR;
          return NoDecision;
        end
        if (dleft == 16'd0) return next_answer();
        ph = dnsp_pkg::PH_A_SKIP;
        return NoDecision;
      end
      dnsp_pkg::PH_A_SKIP: begin
        dleft = dleft - 16'd1;
        if (dleft != 16'd0) return NoDecision;
        return next_answer();
      end
      dnsp_pkg::PH_A_ADDR: begin
        acc   = {acc[23:0], b};
        dleft = dleft - 16'd1;
        return (dleft == 16'd0) ? int'(dnsp_pkg::StFound) : NoDecision;
      end
      default: return NoDecision;
    endcase
  endfunction

  // One accepted byte: at most one result per message, and the end marker
  // forces a truncated result if nothing was decided yet.
  function automatic void parse_byte(logic [7:0] b, logic eom);
    int             st;
    lookup_result_t res;
    if (!decided) begin
      st = consume_byte(b);
      if (st != NoDecision) begin
        decided     = 1'b1;
        ph          = dnsp_pkg::PH_DONE;
        res.status  = st[2:0];
        res.address = (st == int'(dnsp_pkg::StFound)) ? acc : 32'd0;
        awaited_results.push_back(res);
      end
    end
    if (eom) begin
      if (!decided) begin
        res.status  = dnsp_pkg::StTruncated;
        res.address = 32'd0;
        awaited_results.push_back(res);
      end
      messages_ended++;
      clear_parser();
    end
  endfunction

  // --------------------------------------------------------------------------
  // Message builders. Each appends wire-format bytes to msg_bytes.
  // --------------------------------------------------------------------------
  function automatic void put_u16(logic [15:0] v);
    msg_bytes.push_back(v[15:8]);
    msg_bytes.push_back(v[7:0]);
  endfunction

  function automatic void put_random(int n);
    repeat (n) msg_bytes.push_back(8'($urandom));
  endfunction

  function automatic void put_header(logic [15:0] fl, logic [15:0] qd, logic [15:0] an);
    put_random(2);
    put_u16(fl);
    put_u16(qd);
    put_u16(an);
    put_random(4);
  endfunction

  // A tail of zero ends the name with a root label; anything else is the
  // first byte of a pointer, followed by a random offset byte.
  function automatic void put_name(int labels, int label_len, logic [7:0] tail);
    repeat (labels) begin
      msg_bytes.push_back(8'(label_len));
      put_random(label_len);
    end
    msg_bytes.push_back(tail);
    if (tail != 8'h00) put_random(1);
  endfunction

  function automatic logic [7:0] random_tail();
    case ($urandom_range(0, 5))
      3: return {2'b11, 6'($urandom)};
      4: return {2'b01, 6'($urandom)};
      5: return {2'b10, 6'($urandom)};
      default: return 8'h00;
    endcase
  endfunction

  function automatic void put_question();
    put_name($urandom_range(0, 2), $urandom_range(1, 5), random_tail());
    put_random(4);
  endfunction

  // Name, TYPE, CLASS, TTL and RDLENGTH; the caller appends the RDATA.
  function automatic void put_record(int labels, int label_len, logic [7:0] tail,
                                     logic [15:0] rtype, logic [15:0] rdlen);
    put_name(labels, label_len, tail);
    put_u16(rtype);
    put_random(6);
    put_u16(rdlen);
  endfunction

  // Queues the assembled message, keeping only its first keep bytes when
  // keep is positive, and marks the last queued byte as the end.
  function automatic void send_msg(int keep);
    int n;
    n = (keep > 0 && keep < msg_bytes.size()) ? keep : msg_bytes.size();
    for (int i = 0; i < n; i++) begin
      byte_stream.push_back('{data: msg_bytes[i], eom: (i == n - 1)});
    end
    msg_bytes.delete();
  endfunction

  // --------------------------------------------------------------------------
  // Input driver. Works in bursts of random length separated by random gaps.
  // A byte that is stalled is held unchanged until its transfer happens.
  // --------------------------------------------------------------------------
  int burst_left = 1;
  int gap_left = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_vld <= 1'b0;
    end else begin
      if (in_vld && !in_stall) begin
        parse_byte(in_data_byte, in_end_of_message);
        bytes_accepted++;
      end
      if (!in_vld || !in_stall) begin
        if (gap_left > 0 || byte_stream.size() == 0) begin
          if (gap_left > 0) gap_left--;
          in_vld <= 1'b0;
        end else begin
          in_vld            <= 1'b1;
          in_data_byte      <= byte_stream[0].data;
          in_end_of_message <= byte_stream[0].eom;
          void'(byte_stream.pop_front());
          burst_left--;
          if (burst_left == 0) begin
            // Back-to-back bursts now and then, so some stretches never idle.
            burst_left = $urandom_range(1, 40);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result receiver. The stall pattern is redrawn periodically from none,
  // coin-flip, a fixed two-in-five pattern and heavy stalling. Once, after
  // enough bytes have gone in, it holds off for a long stretch so that the
  // result register fills, the byte register backs up and in_stall rises.
  // --------------------------------------------------------------------------
  int rx_cycle = 0;
  int stall_mode = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      rx_cycle++;
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (!hold_done && bytes_accepted >= HoldAfterBytes) begin
        hold_done = 1'b1;
        hold_left = HoldCycles - 1;
        out_stall <= 1'b1;
      end else begin
        if (rx_cycle % 128 == 0) stall_mode = $urandom_range(0, 3);
        case (stall_mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 1) == 1);
          2: out_stall <= ((rx_cycle % 5) < 2);
          default: out_stall <= ($urandom_range(0, 9) < 8);
        endcase
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result checker. Every result transfer must match the oldest awaited one.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    lookup_result_t exp_res;
    if (rst_n && out_vld && !out_stall) begin
      results_checked++;
      status_seen[out_status]++;
      if (awaited_results.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result, status %0d address %h",
                 $time, out_status, out_address);
      end else begin
        exp_res = awaited_results.pop_front();
        if (out_status !== exp_res.status) begin
          mismatches++;
          $display("%0t: status mismatch, expected %0d actual %0d",
                   $time, exp_res.status, out_status);
        end
        if (out_address !== exp_res.address) begin
          mismatches++;
          $display("%0t: address mismatch, expected %h actual %h",
                   $time, exp_res.address, out_address);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus: directed messages, then random ones, then reset and drain.
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int          qd;
    int          an;
    int          claimed;
    int          pick;
    int          target;
    logic [15:0] rtype;
    logic [15:0] rdlen;

    foreach (status_seen[i]) status_seen[i] = 0;
    clear_parser();

    // End marker on the very first byte: truncated.
    msg_bytes.push_back(8'hFF);
    send_msg(0);

    // QR clear with every other flag bit set, trailing bytes ignored.
    put_header(16'h7FFF, 16'd0, 16'd1);
    put_random(3);
    send_msg(0);

    // Largest response code, decided on the final header byte.
    put_header(16'h800F, 16'd0, 16'd0);
    send_msg(0);

    // No questions and no answers: "no A record" right after the header.
    put_header(dnsp_pkg::QrBit, 16'd0, 16'd0);
    send_msg(0);

    // Longest label plus a reserved-form pointer in the question, then a
    // non-A record with empty RDATA, an A record of the wrong length behind
    // the other reserved pointer form, and finally a real A record behind a
    // standard pointer, with an all-ones address on the final byte.
    put_header(16'hFFF0, 16'd1, 16'hFFFF);
    put_name(1, 63, 8'h40);
    put_random(4);
    put_record(2, 3, 8'h00, 16'hFFFF, 16'd0);
    put_record(1, 1, 8'h80, dnsp_pkg::TypeA, 16'd5);
    put_random(5);
    put_record(0, 1, 8'hC0, dnsp_pkg::TypeA, dnsp_pkg::AddrLen);
    repeat (4) msg_bytes.push_back(8'hFF);
    send_msg(0);

    // Root-only name and an all-zero address, then bytes after the decision.
    put_header(dnsp_pkg::QrBit, 16'd0, 16'd2);
    put_record(0, 1, 8'h00, dnsp_pkg::TypeA, dnsp_pkg::AddrLen);
    repeat (4) msg_bytes.push_back(8'h00);
    put_random(4);
    send_msg(0);

    // Two questions and a single non-A answer: counts run out.
    put_header(dnsp_pkg::QrBit, 16'd2, 16'd1);
    put_question();
    put_question();
    put_record(1, 2, 8'h00, 16'h0005, 16'd2);
    put_random(4);
    send_msg(0);

    // Message ends halfway through an address.
    put_header(dnsp_pkg::QrBit, 16'd0, 16'd1);
    put_record(0, 1, 8'hC1, dnsp_pkg::TypeA, dnsp_pkg::AddrLen);
    put_random(2);
    send_msg(0);

    // Huge question count, message ends inside the question section.
    put_header(dnsp_pkg::QrBit, 16'hFFFF, 16'd0);
    put_question();
    send_msg(0);

    target = byte_stream.size() + RandomBytes;
    while (byte_stream.size() < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        // Pure noise.
        put_random($urandom_range(1, 24));
        send_msg(0);
      end else if (pick < 18) begin
        // Arbitrary flags: mostly rejects, sometimes a valid header.
        put_header(16'($urandom), 16'($urandom_range(0, 1)), 16'($urandom_range(0, 1)));
        put_random($urandom_range(0, 6));
        send_msg(0);
      end else begin
        // Well-formed response with random content.
        qd = $urandom_range(0, 2);
        an = $urandom_range(0, 3);
        claimed = an;
        case ($urandom_range(0, 9))
          0: claimed = an + $urandom_range(1, 2);
          1: claimed = 16'hFFFF;
          2: if (an > 0) claimed = an - 1;
          default: ;
        endcase
        put_header((16'($urandom) & 16'h7FF0) | dnsp_pkg::QrBit, 16'(qd), 16'(claimed));
        repeat (qd) put_question();
        repeat (an) begin
          pick = $urandom_range(0, 9);
          if (pick < 4) begin
            rtype = dnsp_pkg::TypeA;
            rdlen = dnsp_pkg::AddrLen;
          end else if (pick < 6) begin
            rtype = dnsp_pkg::TypeA;
            rdlen = 16'($urandom_range(0, 7));
          end else begin
            rtype = 16'($urandom);
            rdlen = 16'($urandom_range(0, 8));
          end
          put_record($urandom_range(0, 2), $urandom_range(1, 5), random_tail(), rtype, rdlen);
          put_random(rdlen);
        end
        if ($urandom_range(0, 3) == 0) put_random($urandom_range(1, 6));
        send_msg(($urandom_range(0, 9) == 0) ? $urandom_range(1, msg_bytes.size()) : 0);
      end
    end

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Wait for the driver to hand over every byte, then for the results.
    while (byte_stream.size() != 0 || in_vld) @(posedge clk);
    for (int i = 0; i < 20000 && awaited_results.size() != 0; i++) @(posedge clk);
    // Keep running so a stray extra result would still be caught.
    repeat (10) @(posedge clk);

    if (awaited_results.size() != 0) begin
      mismatches += awaited_results.size();
      $display("%0t: %0d expected results never arrived", $time, awaited_results.size());
    end

    $display("Sent %0d bytes in %0d messages and checked %0d results, with a %0d-cycle",
             bytes_accepted, messages_ended, results_checked, HoldCycles);
    $display("result hold-off; found/not-response/rcode/no-A/truncated = %0d/%0d/%0d/%0d/%0d",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3], status_seen[4]);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Watchdog far beyond the slowest legal run.
  initial begin
    #5_000_000;
    $display("status: fail");
    $finish;
  end

endmodule

### filelist.f
rtl/dnsp_pkg.sv
rtl/dnsp_step.sv
rtl/dns_answer_address_parser_top.sv
verif/dns_answer_address_parser_top_tb.sv
